// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    // One input item: a raw byte of the string body, or an end-of-input mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       input_end;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_item_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_QUOTE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_UNTERMINATED = 3'd0;
    localparam logic [2:0] ERR_CONTROL      = 3'd1;
    localparam logic [2:0] ERR_ESCAPE       = 3'd2;
    localparam logic [2:0] ERR_HEX          = 3'd3;
    localparam logic [2:0] ERR_SURROGATE    = 3'd4;
    localparam logic [2:0] ERR_UTF8         = 3'd5;

    // Most results one item can cause, and the width of a count of them
    localparam int MaxResults = 4;
    localparam int ResCntW    = $clog2(MaxResults + 1);

    typedef enum logic [10:0] {
        MODE_NORMAL  = 11'b000_0000_0001,
        MODE_ESC     = 11'b000_0000_0010,
        MODE_HEX1    = 11'b000_0000_0100,
        MODE_WANT_BS = 11'b000_0000_1000,
        MODE_WANT_U  = 11'b000_0001_0000,
        MODE_HEX2    = 11'b000_0010_0000,
        MODE_U8_ANY  = 11'b000_0100_0000,
        MODE_U8_E0   = 11'b000_1000_0000,
        MODE_U8_ED   = 11'b001_0000_0000,
        MODE_U8_F0   = 11'b010_0000_0000,
        MODE_U8_F4   = 11'b100_0000_0000
    } mode_t;

    // Decoder state; the hex accumulator keeps only the digits before the last one
    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_count;
        logic [11:0] hex_acc;
        logic [9:0]  high_surr;
        logic [1:0]  utf8_pending;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_RESET = '{MODE_NORMAL, 2'd0, 12'd0, 10'd0, 2'd0};

endpackage

// ===== design/jsu_decode.sv =====
module jsu_decode
    import jsu_pkg::*;
(
    input  dec_state_t                  state,
    input  in_item_t                    item,
    output dec_state_t                  state_next,
    output out_item_t [MaxResults-1:0]  results,
    output logic [ResCntW-1:0]          count
);

    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [ResCntW-1:0]         n;
    } utf8_seq_t;

    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        s.bytes = '0;
        if (cp < 21'h80) begin
            s.bytes[0] = cp[7:0];
            s.n        = ResCntW'(1);
        end
        else if (cp < 21'h800) begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.n        = ResCntW'(2);
        end
        else if (cp < 21'h10000) begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.n        = ResCntW'(3);
        end
        else begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.n        = ResCntW'(4);
        end
        return s;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        if (b inside {[8'h30:8'h39]})
            r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h41:8'h46]})
            r = {1'b1, 4'(b - 8'h37)};
        else if (b inside {[8'h61:8'h66]})
            r = {1'b1, 4'(b - 8'h57)};
        else
            r = 5'd0;
        return r;
    endfunction

    logic [7:0]  b;
    logic [4:0]  hd;
    logic [15:0] hex_val;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        do_quote;
    logic        do_byte;
    logic [7:0]  one_byte;
    logic        do_cp;
    logic [20:0] cp;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;
    logic [1:0]  pending_dec;
    utf8_seq_t   seq;

    assign b       = item.data_byte;
    assign hd      = hex_digit(b);
    assign hex_val = {state.hex_acc, hd[3:0]};

    always_comb
    begin
        state_next  = state;
        do_fail     = 1'b0;
        fail_code   = ERR_UNTERMINATED;
        do_quote    = 1'b0;
        do_byte     = 1'b0;
        one_byte    = b;
        do_cp       = 1'b0;
        cp          = '0;
        cont_lo     = 8'h80;
        cont_hi     = 8'hBF;
        pending_dec = state.utf8_pending - 2'd1;

        if (item.input_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_UNTERMINATED;
        end
        else begin
            case (state.mode)
                MODE_NORMAL:
                begin
                    if (b == 8'h22)
                        do_quote = 1'b1;
                    else if (b == 8'h5C)
                        state_next.mode = MODE_ESC;
                    else if (b < 8'd32) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_CONTROL;
                    end
                    else if (b < 8'd128)
                        do_byte = 1'b1;
                    else begin
                        // Lead byte: pick the range the continuations must fall in
                        do_byte = 1'b1;
                        if (b inside {[8'hC2:8'hDF]}) begin
                            state_next.utf8_pending = 2'd1;
                            state_next.mode         = MODE_U8_ANY;
                        end
                        else if (b == 8'hE0) begin
                            state_next.utf8_pending = 2'd2;
                            state_next.mode         = MODE_U8_E0;
                        end
                        else if (b == 8'hED) begin
                            state_next.utf8_pending = 2'd2;
                            state_next.mode         = MODE_U8_ED;
                        end
                        else if (b inside {[8'hE1:8'hEF]}) begin
                            state_next.utf8_pending = 2'd2;
                            state_next.mode         = MODE_U8_ANY;
                        end
                        else if (b == 8'hF0) begin
                            state_next.utf8_pending = 2'd3;
                            state_next.mode         = MODE_U8_F0;
                        end
                        else if (b inside {[8'hF1:8'hF3]}) begin
                            state_next.utf8_pending = 2'd3;
                            state_next.mode         = MODE_U8_ANY;
                        end
                        else if (b == 8'hF4) begin
                            state_next.utf8_pending = 2'd3;
                            state_next.mode         = MODE_U8_F4;
                        end
                        else begin
                            do_byte   = 1'b0;
                            do_fail   = 1'b1;
                            fail_code = ERR_UTF8;
                        end
                    end
                end
                MODE_ESC:
                begin
                    state_next.mode = MODE_NORMAL;
                    do_byte         = 1'b1;
                    case (b)
                        8'h22, 8'h5C, 8'h2F: one_byte = b;
                        8'h62:               one_byte = 8'h08;
                        8'h66:               one_byte = 8'h0C;
                        8'h6E:               one_byte = 8'h0A;
                        8'h72:               one_byte = 8'h0D;
                        8'h74:               one_byte = 8'h09;
                        8'h75:
                        begin
                            do_byte              = 1'b0;
                            state_next.mode      = MODE_HEX1;
                            state_next.hex_count = 2'd0;
                            state_next.hex_acc   = '0;
                        end
                        default:
                        begin
                            do_byte   = 1'b0;
                            do_fail   = 1'b1;
                            fail_code = ERR_ESCAPE;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    if (!hd[4]) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_HEX;
                    end
                    else if (state.hex_count != 2'd3) begin
                        state_next.hex_count = state.hex_count + 2'd1;
                        state_next.hex_acc   = {state.hex_acc[7:0], hd[3:0]};
                    end
                    else begin
                        state_next.hex_count = 2'd0;
                        state_next.hex_acc   = '0;
                        if (state.mode == MODE_HEX1) begin
                            if (hex_val inside {[16'hD800:16'hDBFF]}) begin
                                state_next.high_surr = hex_val[9:0];
                                state_next.mode      = MODE_WANT_BS;
                            end
                            else if (hex_val inside {[16'hDC00:16'hDFFF]}) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_SURROGATE;
                            end
                            else begin
                                state_next.mode = MODE_NORMAL;
                                do_cp           = 1'b1;
                                cp              = {5'd0, hex_val};
                            end
                        end
                        else begin
                            if (!(hex_val inside {[16'hDC00:16'hDFFF]})) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_SURROGATE;
                            end
                            else begin
                                // Pair value: 0x10000 plus high and low offsets
                                state_next.mode      = MODE_NORMAL;
                                state_next.high_surr = '0;
                                do_cp                = 1'b1;
                                cp = 21'h10000 + {1'b0, state.high_surr, hex_val[9:0]};
                            end
                        end
                    end
                end
                MODE_WANT_BS:
                begin
                    if (b != 8'h5C) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_SURROGATE;
                    end
                    else
                        state_next.mode = MODE_WANT_U;
                end
                MODE_WANT_U:
                begin
                    if (b != 8'h75) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_SURROGATE;
                    end
                    else begin
                        state_next.mode      = MODE_HEX2;
                        state_next.hex_count = 2'd0;
                        state_next.hex_acc   = '0;
                    end
                end
                MODE_U8_ANY, MODE_U8_E0, MODE_U8_ED, MODE_U8_F0, MODE_U8_F4:
                begin
                    if (state.mode == MODE_U8_E0)
                        cont_lo = 8'hA0;
                    else if (state.mode == MODE_U8_ED)
                        cont_hi = 8'h9F;
                    else if (state.mode == MODE_U8_F0)
                        cont_lo = 8'h90;
                    else if (state.mode == MODE_U8_F4)
                        cont_hi = 8'h8F;
                    if (b < cont_lo || b > cont_hi) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_UTF8;
                    end
                    else begin
                        do_byte                 = 1'b1;
                        state_next.utf8_pending = pending_dec;
                        state_next.mode = (pending_dec != 2'd0) ? MODE_U8_ANY : MODE_NORMAL;
                    end
                end
                default:
                    state_next = DEC_STATE_RESET;
            endcase
        end

        // Drop back to the start of a string after a quote or an error
        if (do_fail || do_quote)
            state_next = DEC_STATE_RESET;
    end

    assign seq = utf8_encode(cp);

    always_comb
    begin
        results = '0;
        count   = '0;
        if (do_fail) begin
            results[0].kind       = KIND_ERROR;
            results[0].error_code = fail_code;
            count                 = ResCntW'(1);
        end
        else if (do_quote) begin
            results[0].kind = KIND_QUOTE;
            count           = ResCntW'(1);
        end
        else if (do_byte) begin
            results[0].out_byte = one_byte;
            results[0].kind     = KIND_BYTE;
            count               = ResCntW'(1);
        end
        else if (do_cp) begin
            for (int i = 0; i < MaxResults; i++) begin
                results[i].out_byte = seq.bytes[i];
                results[i].kind     = KIND_BYTE;
            end
            count = seq.n;
        end
        for (int i = 0; i < MaxResults; i++)
            results[i].last_of_run = (ResCntW'(i + 1) == count);
    end

endmodule

// ===== design/json_string_unescaper.sv =====
// Channel   Signals                                Moves
// ------    -------------------------------------  ----------------------------------
// byte      byte_valid, byte_ready, byte_item      raw string byte or end-of-input
// res       res_valid, res_ready, res_item         decoded byte, quote or error
//
// An item is registered on entry in the input register, decoded, and its results are loaded
// into a four-deep result buffer, from which the first result is offered.
// The result port drains one result per cycle while res_ready is high, so an item with n
// results (n is 1 to 4) keeps the next item waiting until its last result leaves; items with
// no result only update the decoder state. Single-result items stream at one per cycle while res_ready stays high.
// Reset clears the decoder state and the valid flags of the input register and result buffer.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_item_t  byte_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    logic                       in_valid_reg;
    in_item_t                   in_item_reg;
    dec_state_t                 state_reg;
    dec_state_t                 state_next;
    out_item_t [MaxResults-1:0] buf_reg;
    logic [ResCntW-1:0]         buf_cnt_reg;
    out_item_t [MaxResults-1:0] dec_results;
    logic [ResCntW-1:0]         dec_count;
    logic                       pop;
    logic                       buf_free;
    logic                       take;

    jsu_decode u_decode (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .results    (dec_results),
        .count      (dec_count)
    );

    assign res_valid  = (buf_cnt_reg != '0);
    assign res_item   = buf_reg[0];
    assign pop        = res_valid && res_ready;
    // Buffer can take new results when empty or when its last one leaves now
    assign buf_free   = (buf_cnt_reg == '0) || (pop && buf_cnt_reg == ResCntW'(1));
    assign take       = in_valid_reg && buf_free;
    assign byte_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            state_reg    <= DEC_STATE_RESET;
            buf_cnt_reg  <= '0;
        end
        else begin
            if (byte_ready)
                in_valid_reg <= byte_valid;
            if (take)
                state_reg <= state_next;
            if (take && dec_count != '0)
                buf_cnt_reg <= dec_count;
            else if (pop)
                buf_cnt_reg <= buf_cnt_reg - ResCntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_item_reg <= byte_item;
        if (take && dec_count != '0)
            buf_reg <= dec_results;
        else if (pop) begin
            // Advance the queue by one result
            for (int i = 0; i < MaxResults - 1; i++)
                buf_reg[i] <= buf_reg[i + 1];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= ResCntW'(MaxResults))
        else $error("result buffer count above depth");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.last_of_run |=> res_valid)
        else $error("result run ended without last_of_run");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind != KIND_BYTE |-> res_item.last_of_run)
        else $error("quote or error result not last of its run");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && dec_count == ResCntW'(1) && dec_results[0].kind != KIND_BYTE
        |=> state_reg == DEC_STATE_RESET)
        else $error("decoder state not cleared after quote or error");

endmodule

// ===== verif/json_string_unescaper_tb.sv =====
`timescale 1ns / 1ps

module json_string_unescaper_tb;
    import jsu_pkg::*;

    // Predicts the decoded stream and checks each result against it
    class unescape_scoreboard;
        out_item_t   expected_out[$];
        out_item_t   step_out[$];
        int          mismatches;
        mode_t       mode;
        int          hex_count;
        logic [15:0] hex_acc;
        logic [9:0]  high_surr;
        int          utf8_left;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            mode      = MODE_NORMAL;
            hex_count = 0;
            hex_acc   = 16'h0000;
            high_surr = 10'h000;
            utf8_left = 0;
        endfunction

        function void add(logic [7:0] b, logic [1:0] k, logic [2:0] e);
            out_item_t r;
            r.out_byte    = b;
            r.kind        = k;
            r.error_code  = e;
            r.last_of_run = 1'b0;
            step_out = {step_out, r};
        endfunction

        function void raise_error(logic [2:0] e);
            clear();
            add(8'h00, KIND_ERROR, e);
        endfunction

        function void emit_utf8(logic [20:0] cp);
            if (cp < 21'h80) begin
                add(cp[7:0], KIND_BYTE, ERR_UNTERMINATED);
            end
            else if (cp < 21'h800) begin
                add({3'b110, cp[10:6]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[5:0]}, KIND_BYTE, ERR_UNTERMINATED);
            end
            else if (cp < 21'h10000) begin
                add({4'b1110, cp[15:12]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[11:6]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[5:0]}, KIND_BYTE, ERR_UNTERMINATED);
            end
            else begin
                add({5'b11110, cp[20:18]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[17:12]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[11:6]}, KIND_BYTE, ERR_UNTERMINATED);
                add({2'b10, cp[5:0]}, KIND_BYTE, ERR_UNTERMINATED);
            end
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b) - 48;
            if (b >= "A" && b <= "F") return int'(b) - 55;
            if (b >= "a" && b <= "f") return int'(b) - 87;
            return -1;
        endfunction

        function void take_hex(logic [7:0] b, bit second);
            int          d;
            logic [15:0] v;
            logic [20:0] cp;
            d = hex_digit(b);
            if (d < 0) begin
                raise_error(ERR_HEX);
                return;
            end
            hex_acc = {hex_acc[11:0], d[3:0]};
            hex_count++;
            if (hex_count < 4) return;
            v         = hex_acc;
            hex_count = 0;
            hex_acc   = 16'h0000;
            if (!second) begin
                if (v >= 16'hD800 && v <= 16'hDBFF) begin
                    // hold the high half until its partner arrives
                    high_surr = v[9:0];
                    mode      = MODE_WANT_BS;
                    return;
                end
                if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                    raise_error(ERR_SURROGATE);
                    return;
                end
                mode = MODE_NORMAL;
                emit_utf8({5'd0, v});
                return;
            end
            if (v < 16'hDC00 || v > 16'hDFFF) begin
                raise_error(ERR_SURROGATE);
                return;
            end
            cp        = 21'h10000 + {1'b0, high_surr, v[9:0]};
            high_surr = 10'h000;
            mode      = MODE_NORMAL;
            emit_utf8(cp);
        endfunction

        function void decode_input(in_item_t it);
            logic [7:0] b;
            logic [7:0] c;
            logic [7:0] lo;
            logic [7:0] hi;
            bit         ok;
            b = it.data_byte;
            step_out.delete();
            if (it.input_end) begin
                raise_error(ERR_UNTERMINATED);
            end
            else begin
                case (mode)
                    MODE_NORMAL: begin
                        if (b == "\"") begin
                            clear();
                            add(8'h00, KIND_QUOTE, ERR_UNTERMINATED);
                        end
                        else if (b == "\\") begin
                            mode = MODE_ESC;
                        end
                        else if (b < 8'd32) begin
                            raise_error(ERR_CONTROL);
                        end
                        else if (b < 8'd128) begin
                            add(b, KIND_BYTE, ERR_UNTERMINATED);
                        end
                        else begin
                            if (b >= 8'hC2 && b <= 8'hDF) begin
                                utf8_left = 1;
                                mode      = MODE_U8_ANY;
                            end
                            else if (b == 8'hE0) begin
                                utf8_left = 2;
                                mode      = MODE_U8_E0;
                            end
                            else if (b == 8'hED) begin
                                utf8_left = 2;
                                mode      = MODE_U8_ED;
                            end
                            else if (b >= 8'hE1 && b <= 8'hEF) begin
                                utf8_left = 2;
                                mode      = MODE_U8_ANY;
                            end
                            else if (b == 8'hF0) begin
                                utf8_left = 3;
                                mode      = MODE_U8_F0;
                            end
                            else if (b >= 8'hF1 && b <= 8'hF3) begin
                                utf8_left = 3;
                                mode      = MODE_U8_ANY;
                            end
                            else if (b == 8'hF4) begin
                                utf8_left = 3;
                                mode      = MODE_U8_F4;
                            end
                            // no lead matched: mode is still normal
                            if (mode == MODE_NORMAL) raise_error(ERR_UTF8);
                            else add(b, KIND_BYTE, ERR_UNTERMINATED);
                        end
                    end
                    MODE_ESC: begin
                        ok = 1'b1;
                        c  = b;
                        case (b)
                            "\"", "\\", "/": c = b;
                            "b":             c = 8'h08;
                            "f":             c = 8'h0C;
                            "n":             c = 8'h0A;
                            "r":             c = 8'h0D;
                            "t":             c = 8'h09;
                            default:         ok = 1'b0;
                        endcase
                        if (b == "u") begin
                            mode      = MODE_HEX1;
                            hex_count = 0;
                            hex_acc   = 16'h0000;
                        end
                        else if (ok) begin
                            mode = MODE_NORMAL;
                            add(c, KIND_BYTE, ERR_UNTERMINATED);
                        end
                        else begin
                            raise_error(ERR_ESCAPE);
                        end
                    end
                    MODE_HEX1: take_hex(b, 1'b0);
                    MODE_WANT_BS: begin
                        if (b != "\\") raise_error(ERR_SURROGATE);
                        else mode = MODE_WANT_U;
                    end
                    MODE_WANT_U: begin
                        if (b != "u") begin
                            raise_error(ERR_SURROGATE);
                        end
                        else begin
                            mode      = MODE_HEX2;
                            hex_count = 0;
                            hex_acc   = 16'h0000;
                        end
                    end
                    MODE_HEX2: take_hex(b, 1'b1);
                    MODE_U8_ANY, MODE_U8_E0, MODE_U8_ED, MODE_U8_F0, MODE_U8_F4: begin
                        lo = 8'h80;
                        hi = 8'hBF;
                        if (mode == MODE_U8_E0) lo = 8'hA0;
                        else if (mode == MODE_U8_ED) hi = 8'h9F;
                        else if (mode == MODE_U8_F0) lo = 8'h90;
                        else if (mode == MODE_U8_F4) hi = 8'h8F;
                        if (b < lo || b > hi) begin
                            raise_error(ERR_UTF8);
                        end
                        else begin
                            utf8_left--;
                            mode = (utf8_left != 0) ? MODE_U8_ANY : MODE_NORMAL;
                            add(b, KIND_BYTE, ERR_UNTERMINATED);
                        end
                    end
                    default: clear();
                endcase
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last_of_run = 1'b1;
            expected_out = {expected_out, step_out};
        endfunction

        function void check_output(out_item_t got);
            out_item_t want;
            if (expected_out.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result byte %02h kind %0d err %0d last %0b",
                             $realtime, got.out_byte, got.kind, got.error_code,
                             got.last_of_run);
                mismatches++;
                return;
            end
            want = expected_out.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.error_code !== want.error_code || got.last_of_run !== want.last_of_run)
            begin
                if (mismatches < 10)
                    $display("%0t: mismatch: expected byte %02h kind %0d err %0d last %0b, %s",
                             $realtime, want.out_byte, want.kind, want.error_code,
                             want.last_of_run,
                             $sformatf("got byte %02h kind %0d err %0d last %0b",
                                       got.out_byte, got.kind, got.error_code,
                                       got.last_of_run));
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_out.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    in_item_t  byte_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    in_item_t stim_q[$];
    unescape_scoreboard sb = new();

    json_string_unescaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_item (byte_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                res_ready <= 1'b0;
                hold_cycles--;
            end
            else begin
                res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (byte_valid && byte_ready) sb.decode_input(byte_item);
            if (res_valid && res_ready) sb.check_output(res_item);
        end
    end

    task automatic send_byte(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do @(posedge clk); while (!byte_ready);
    endtask

    task automatic send_queue();
        foreach (stim_q[i]) send_byte(stim_q[i]);
        stim_q.delete();
    endtask

    // Drop valid and wait for every expected result
    task automatic drain_results();
        byte_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void put_byte(logic [7:0] b);
        in_item_t it;
        it.data_byte = b;
        it.input_end = 1'b0;
        stim_q = {stim_q, it};
    endfunction

    function automatic void put_end();
        in_item_t it;
        it.data_byte = 8'($urandom_range(0, 255));
        it.input_end = 1'b1;
        stim_q = {stim_q, it};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void put_u(logic [15:0] v);
        put_byte("\\");
        put_byte("u");
        for (int i = 3; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
    endfunction

    function automatic logic [7:0] non_hex();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 47));
            1:       return 8'($urandom_range(58, 64));
            2:       return 8'($urandom_range(71, 96));
            default: return 8'($urandom_range(103, 255));
        endcase
    endfunction

    function automatic logic [7:0] printable();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 126)); while (b == "\"" || b == "\\");
        return b;
    endfunction

    // Random Unicode scalar value, boundary values favored
    function automatic logic [20:0] pick_scalar();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 7))
                    0:       return 21'h80;
                    1:       return 21'h7FF;
                    2:       return 21'h800;
                    3:       return 21'hD7FF;
                    4:       return 21'hE000;
                    5:       return 21'hFFFF;
                    6:       return 21'h10000;
                    default: return 21'h10FFFF;
                endcase
            end
            1:       return 21'($urandom_range(0, 'h7F));
            2:       return 21'($urandom_range('h80, 'h7FF));
            3:       return 21'($urandom_range('h800, 'hD7FF));
            4:       return 21'($urandom_range('hE000, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    function automatic void put_u_scalar(logic [20:0] cp);
        logic [19:0] off;
        if (cp >= 21'h10000) begin
            off = 20'(cp - 21'h10000);
            put_u(16'hD800 + 16'(off[19:10]));
            put_u(16'hDC00 + 16'(off[9:0]));
        end
        else begin
            put_u(cp[15:0]);
        end
    endfunction

    function automatic void put_raw_utf8();
        logic [20:0] cp;
        do cp = pick_scalar(); while (cp < 21'h80);
        if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
        end
        else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
        end
        else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
        end
        put_byte({2'b10, cp[5:0]});
    endfunction

    function automatic void build_good_string();
        logic [7:0] esc_chars[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
        int         n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_byte(printable());
                4, 5: begin
                    put_byte("\\");
                    put_byte(esc_chars[$urandom_range(0, 7)]);
                end
                6, 7:    put_u_scalar(pick_scalar());
                default: put_raw_utf8();
            endcase
        end
        if ($urandom_range(0, 9) == 0) put_end();
        else put_byte("\"");
    endfunction

    function automatic void build_broken();
        logic [7:0] b;
        int         k;
        if ($urandom_range(0, 1)) put_byte(printable());
        case ($urandom_range(0, 8))
            0: put_u(16'($urandom_range('hDC00, 'hDFFF)));
            1: begin
                // high surrogate with no proper partner
                put_u(16'($urandom_range('hD800, 'hDBFF)));
                case ($urandom_range(0, 2))
                    0: begin
                        do b = 8'($urandom_range(0, 255)); while (b == "\\");
                        put_byte(b);
                    end
                    1: begin
                        put_byte("\\");
                        do b = 8'($urandom_range(0, 255)); while (b == "u");
                        put_byte(b);
                    end
                    default: begin
                        if ($urandom_range(0, 1)) put_u(16'($urandom_range(0, 'hDBFF)));
                        else put_u(16'($urandom_range('hE000, 'hFFFF)));
                    end
                endcase
            end
            2: begin
                if ($urandom_range(0, 1)) put_u(16'($urandom_range('hD800, 'hDBFF)));
                put_byte("\\");
                put_byte("u");
                k = $urandom_range(0, 3);
                repeat (k) put_byte(hex_char(4'($urandom_range(0, 15))));
                put_byte(non_hex());
            end
            3: begin
                put_byte("\\");
                do b = 8'($urandom_range(0, 255));
                while (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
                put_byte(b);
            end
            4: begin
                if ($urandom_range(0, 1)) put_byte(8'($urandom_range('h80, 'hC1)));
                else put_byte(8'($urandom_range('hF5, 'hFF)));
            end
            5: begin
                case ($urandom_range(0, 5))
                    0: begin
                        put_byte(8'($urandom_range('hC2, 'hDF)));
                        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 'h7F)));
                        else put_byte(8'($urandom_range('hC0, 'hFF)));
                    end
                    1: begin
                        put_byte(8'hE0);
                        put_byte(8'($urandom_range('h80, 'h9F)));
                    end
                    2: begin
                        put_byte(8'hED);
                        put_byte(8'($urandom_range('hA0, 'hBF)));
                    end
                    3: begin
                        put_byte(8'hF0);
                        put_byte(8'($urandom_range('h80, 'h8F)));
                    end
                    4: begin
                        put_byte(8'hF4);
                        put_byte(8'($urandom_range('h90, 'hBF)));
                    end
                    default: begin
                        // bad byte later in a longer sequence
                        put_byte(8'($urandom_range('hF1, 'hF3)));
                        put_byte(8'($urandom_range('h80, 'hBF)));
                        if ($urandom_range(0, 1)) put_byte(8'($urandom_range('h80, 'hBF)));
                        put_byte(8'($urandom_range('hC0, 'hFF)));
                    end
                endcase
            end
            6: put_byte(8'($urandom_range(0, 31)));
            7: begin
                case ($urandom_range(0, 4))
                    0: put_byte("\\");
                    1: begin
                        put_byte("\\");
                        put_byte("u");
                        put_byte(hex_char(4'($urandom_range(0, 15))));
                    end
                    2: put_u(16'($urandom_range('hD800, 'hDBFF)));
                    3: begin
                        put_u(16'($urandom_range('hD800, 'hDBFF)));
                        put_byte("\\");
                    end
                    default: begin
                        put_byte(8'($urandom_range('hF1, 'hF3)));
                        put_byte(8'h80);
                    end
                endcase
                put_end();
            end
            default: begin
                k = $urandom_range(1, 8);
                repeat (k) begin
                    if ($urandom_range(0, 19) == 0) put_end();
                    else put_byte(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endfunction

    task automatic run_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 75) build_good_string();
            else build_broken();
            sent += stim_q.size();
            send_queue();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 47;
        // printable extremes, \u0000, the highest pair, a closing quote
        put_byte(8'h20);
        put_byte(8'h7E);
        put_u(16'h0000);
        put_u(16'hDBFF);
        put_u(16'hDFFF);
        put_byte("\"");
        // control byte, bad lead, lone low surrogate, end of input
        put_byte(8'h1F);
        put_byte(8'hFF);
        put_u(16'hDC00);
        put_end();
        send_queue();
        run_random(55);
        drain_results();

        send_idle_pct = 47;
        recv_idle_pct = 26;
        run_random(55);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(25);
        drain_results();
        // stall the result side while items keep coming
        hold_cycles = 300;
        run_random(30);
        drain_results();
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/jsu_pkg.sv
design/jsu_decode.sv
design/json_string_unescaper.sv
verif/json_string_unescaper_tb.sv
